/* hdl/trcc_pkg.sv */
package trcc_pkg;

  // Width of the cursor and region coordinates held in state
  localparam int COORD_BITS = 8;
  localparam int CW         = COORD_BITS;

  // Fixed field widths of the command, result and configuration items
  localparam int OP_W   = 4;
  localparam int ARG_W  = 8;
  localparam int OUT_W  = 8;
  localparam int CFG_W  = 9;
  localparam int IDX_W  = 1;

  // Largest usable screen size and the widths used to compare against it
  localparam int SIZE_MAX = 1 << CW;
  localparam int CMP_W    = (CFG_W > CW + 1) ? CFG_W : CW + 1;
  localparam int UW       = (ARG_W > CW) ? ARG_W : CW;

  // Configuration register indexes and reset values
  localparam logic [IDX_W-1:0] REG_COLS = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_ROWS = IDX_W'(1);
  localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(80);
  localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(24);

  typedef enum logic [OP_W-1:0] {
    OP_UP      = 4'd0,
    OP_DOWN    = 4'd1,
    OP_RIGHT   = 4'd2,
    OP_LEFT    = 4'd3,
    OP_MOVE    = 4'd4,
    OP_REGION  = 4'd5,
    OP_LF      = 4'd6,
    OP_RI      = 4'd7,
    OP_CR      = 4'd8
  } op_e;

  typedef struct packed {
    logic [CW-1:0] col;
    logic [CW-1:0] row;
    logic [CW-1:0] top;
    logic [CW-1:0] bot;
  } cur_state_t;

  typedef struct packed {
    logic scroll_up;
    logic scroll_down;
    logic region_rejected;
  } flags_t;

  // Last valid index for a screen size: 0 reads as 1, oversize saturates
  function automatic logic [CW-1:0] last_idx(input logic [CFG_W-1:0] v);
    logic [CMP_W-1:0] ve;
    ve = CMP_W'(v);
    if (v == '0) begin
      return '0;
    end else if (ve > CMP_W'(SIZE_MAX)) begin
      return CW'(SIZE_MAX - 1);
    end else begin
      return CW'(ve - CMP_W'(1));
    end
  endfunction

  function automatic logic [UW-1:0] min_u(input logic [UW-1:0] x, input logic [UW-1:0] y);
    return (x < y) ? x : y;
  endfunction

endpackage

/* hdl/trcc_step.sv */
module trcc_step import trcc_pkg::*; (
  input  cur_state_t       st_i,
  input  logic [OP_W-1:0]  op_i,
  input  logic [ARG_W-1:0] first_arg_i,
  input  logic [ARG_W-1:0] second_arg_i,
  input  logic [CW-1:0]    last_col_i,
  input  logic [CW-1:0]    last_row_i,
  output cur_state_t       nxt_o,
  output flags_t           flags_o
);

  logic [UW-1:0] a_w, b_w, n_w, cx_w, cy_w, top_w, bot_w, lc_w, lr_w;
  logic [UW-1:0] lim_w, dn_w, t_w, u_w;

  // Widen everything to one compare width
  assign a_w   = UW'(first_arg_i);
  assign b_w   = UW'(second_arg_i);
  assign n_w   = (first_arg_i == '0) ? UW'(1) : a_w;
  assign cx_w  = UW'(st_i.col);
  assign cy_w  = UW'(st_i.row);
  assign top_w = UW'(st_i.top);
  assign bot_w = UW'(st_i.bot);
  assign lc_w  = UW'(last_col_i);
  assign lr_w  = UW'(last_row_i);
  assign t_w   = min_u(a_w, lr_w);
  assign u_w   = min_u(b_w, lr_w);

  // Apply one command to the cursor and region
  always_comb begin
    nxt_o   = st_i;
    flags_o = '0;
    lim_w   = '0;
    dn_w    = '0;
    unique case (op_e'(op_i))
      OP_UP: begin
        lim_w     = (cy_w < top_w) ? cy_w : cy_w - top_w;
        dn_w      = min_u(n_w, lim_w);
        nxt_o.row = CW'(cy_w - dn_w);
      end
      OP_DOWN: begin
        if (cy_w > bot_w) begin
          lim_w = (lr_w > cy_w) ? lr_w - cy_w : '0;
        end else begin
          lim_w = bot_w - cy_w;
        end
        dn_w      = min_u(n_w, lim_w);
        nxt_o.row = CW'(cy_w + dn_w);
      end
      OP_RIGHT: begin
        lim_w     = (lc_w > cx_w) ? lc_w - cx_w : '0;
        dn_w      = min_u(n_w, lim_w);
        nxt_o.col = CW'(cx_w + dn_w);
      end
      OP_LEFT: begin
        dn_w      = min_u(n_w, cx_w);
        nxt_o.col = CW'(cx_w - dn_w);
      end
      OP_MOVE: begin
        nxt_o.col = CW'(min_u(a_w, lc_w));
        nxt_o.row = CW'(min_u(b_w, lr_w));
      end
      OP_REGION: begin
        if (t_w >= u_w) begin
          flags_o.region_rejected = 1'b1;
        end else begin
          nxt_o.col = '0;
          nxt_o.row = '0;
          nxt_o.top = CW'(t_w);
          nxt_o.bot = CW'(u_w);
        end
      end
      OP_LF: begin
        if (st_i.row == st_i.bot) begin
          flags_o.scroll_up = 1'b1;
        end else if (st_i.row < last_row_i) begin
          nxt_o.row = st_i.row + CW'(1);
        end
      end
      OP_RI: begin
        if (st_i.row == st_i.top) begin
          flags_o.scroll_down = 1'b1;
        end else if (st_i.row != '0) begin
          nxt_o.row = st_i.row - CW'(1);
        end
      end
      OP_CR: begin
        nxt_o.col = '0;
      end
      default: begin
        nxt_o = st_i;
      end
    endcase
  end

endmodule

/* hdl/trcc_state.sv */
module trcc_state import trcc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             upd_i,
  input  cur_state_t       nxt_i,
  output cur_state_t       st_o,
  output logic [CW-1:0]    last_col_o,
  output logic [CW-1:0]    last_row_o
);

  logic [CFG_W-1:0] cols_q, rows_q;
  cur_state_t       st_q;
  logic [CW-1:0]    cfg_last;

  assign cfg_last   = last_idx(cfg_data_i);
  assign last_col_o = last_idx(cols_q);
  assign last_row_o = last_idx(rows_q);
  assign st_o       = st_q;

  // Take screen size writes, else advance on each command transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q     <= COLS_RESET;
      rows_q     <= ROWS_RESET;
      st_q.col   <= '0;
      st_q.row   <= '0;
      st_q.top   <= '0;
      st_q.bot   <= last_idx(ROWS_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_COLS: begin
          cols_q <= cfg_data_i;
          if (st_q.col > cfg_last) begin
            st_q.col <= cfg_last;
          end
        end
        REG_ROWS: begin
          rows_q   <= cfg_data_i;
          st_q.top <= '0;
          st_q.bot <= cfg_last;
          if (st_q.row > cfg_last) begin
            st_q.row <= cfg_last;
          end
        end
        default: begin
          cols_q <= cols_q;
        end
      endcase
    end else if (upd_i) begin
      st_q <= nxt_i;
    end
  end

  // Region stays ordered and on screen, cursor stays on screen
  a_region_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.top <= st_q.bot) else $error("region top below bottom");

  a_region_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.bot <= last_row_o) else $error("region bottom off screen");

  a_cursor_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.row <= last_row_o) && (st_q.col <= last_col_o))
    else $error("cursor off screen");

endmodule

/* hdl/terminal_cursor_region_control.sv */
// Cursor and scroll-region control for a text terminal. Each command on the
// slave stream yields exactly one result on the master stream carrying the
// cursor and region after the command plus the scroll and reject flags.
// Commands are taken one per clock cycle while results are taken; a result is
// valid once its command has moved through the command register into the
// result register. A single step of compare and subtract logic lies between
// the command register and the cursor state. A result waiting on the master
// side still lets one more command into the command register; further
// commands stall until that result is taken. Screen size writes on the
// configuration port are expected only while no command is in flight.
module terminal_cursor_region_control import trcc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Configuration writes
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  // Command stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [23:0]      s_axis_tdata,   // op[3:0], first_arg[11:4], second_arg[19:12]
  // Result stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // cursor_col[7:0], cursor_row[15:8],
                                           // region_top[23:16], region_bottom[31:24]
  output logic [2:0]       m_axis_tuser    // scroll_up[0], scroll_down[1], region_rejected[2]
);

  logic             in_valid_q, out_valid_q;
  logic [OP_W-1:0]  op_q;
  logic [ARG_W-1:0] a_q, b_q;
  logic             adv;
  cur_state_t       st, nxt;
  flags_t           flags, flags_q;
  logic [CW-1:0]    last_col, last_row;
  logic [31:0]      res_q;

  // Move a command into the result register when that slot is free
  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  // Hold the command register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      op_q <= s_axis_tdata[OP_W-1:0];
      a_q  <= s_axis_tdata[OP_W+ARG_W-1:OP_W];
      b_q  <= s_axis_tdata[OP_W+2*ARG_W-1:OP_W+ARG_W];
    end
  end

  trcc_state u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .upd_i      (adv),
    .nxt_i      (nxt),
    .st_o       (st),
    .last_col_o (last_col),
    .last_row_o (last_row)
  );

  trcc_step u_step (
    .st_i         (st),
    .op_i         (op_q),
    .first_arg_i  (a_q),
    .second_arg_i (b_q),
    .last_col_i   (last_col),
    .last_row_i   (last_row),
    .nxt_o        (nxt),
    .flags_o      (flags)
  );

  // Hold the result until its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q   <= {OUT_W'(nxt.bot), OUT_W'(nxt.top), OUT_W'(nxt.row), OUT_W'(nxt.col)};
      flags_q <= flags;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;
  assign m_axis_tuser  = {flags_q.region_rejected, flags_q.scroll_down, flags_q.scroll_up};

  // Command side stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("command side stalled without a stalled result");

  // A pending command with a free result slot shows up as a result
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !(m_axis_tvalid && !m_axis_tready)) |=> m_axis_tvalid)
    else $error("pending command did not reach the result register");

  // At most one flag per result
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0(m_axis_tuser))
    else $error("more than one result flag set");

endmodule

/* dv/terminal_cursor_region_control_tb.sv */
module terminal_cursor_region_control_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import trcc_pkg::*;

  localparam int ITEMS_PER_PHASE = 160;
  localparam int PHASES          = 8;
  localparam int STALL_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int LONG_HOLD       = 300;
  localparam int LONG_HOLD_AT    = 400;
  localparam int MAX_PRINTED     = 100;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [ARG_W-1:0] first;
    logic [ARG_W-1:0] second;
  } command_t;

  typedef struct packed {
    logic [OUT_W-1:0] col;
    logic [OUT_W-1:0] row;
    logic [OUT_W-1:0] top;
    logic [OUT_W-1:0] bot;
    logic             scroll_up;
    logic             scroll_down;
    logic             rejected;
  } cursor_view_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [ARG_W-1:0] first;
    logic [ARG_W-1:0] second;
    logic             typed;
    cursor_view_t     view;
  } opening_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [23:0]      s_axis_tdata;   // op[3:0], first_arg[11:4], second_arg[19:12]
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [31:0]      m_axis_tdata;   // cursor_col[7:0], cursor_row[15:8],
                                    // region_top[23:16], region_bottom[31:24]
  logic [2:0]       m_axis_tuser;   // scroll_up[0], scroll_down[1], region_rejected[2]

  terminal_cursor_region_control dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Terminal state as the predictor sees it
  logic [CFG_W-1:0] cfg_cols;
  logic [CFG_W-1:0] cfg_rows;
  logic [OUT_W-1:0] term_col;
  logic [OUT_W-1:0] term_row;
  logic [OUT_W-1:0] scroll_top;
  logic [OUT_W-1:0] scroll_bot;

  cursor_view_t expected_views[$];
  int           mismatches;
  int           views_checked;
  bit           sender_lazy;
  bit           receiver_lazy;

  // Screen sizes per phase: one-cell, zero, full, oversize, tiny, wide, tall, default
  logic [CFG_W-1:0] phase_cols [PHASES] = '{9'd1, 9'd0, 9'd256, 9'd511,
                                            9'd2, 9'd132, 9'd17, 9'd80};
  logic [CFG_W-1:0] phase_rows [PHASES] = '{9'd1, 9'd0, 9'd256, 9'd300,
                                            9'd2, 9'd50, 9'd255, 9'd24};

  // Opening commands on the reset screen of 80 by 24
  opening_row_t opening_rows [27] = '{
    '{OP_UP,     8'd0,   8'd0,   1'b1, '{8'd0,  8'd0,  8'd0, 8'd23, 1'b0, 1'b0, 1'b0}},
    '{OP_MOVE,   8'd255, 8'd255, 1'b1, '{8'd79, 8'd23, 8'd0, 8'd23, 1'b0, 1'b0, 1'b0}},
    '{OP_RIGHT,  8'd255, 8'd0,   1'b1, '{8'd79, 8'd23, 8'd0, 8'd23, 1'b0, 1'b0, 1'b0}},
    '{OP_DOWN,   8'd0,   8'd0,   1'b1, '{8'd79, 8'd23, 8'd0, 8'd23, 1'b0, 1'b0, 1'b0}},
    '{OP_LF,     8'd0,   8'd0,   1'b1, '{8'd79, 8'd23, 8'd0, 8'd23, 1'b1, 1'b0, 1'b0}},
    '{OP_CR,     8'd0,   8'd0,   1'b1, '{8'd0,  8'd23, 8'd0, 8'd23, 1'b0, 1'b0, 1'b0}},
    '{OP_LEFT,   8'd0,   8'd0,   1'b0, '0},
    '{OP_REGION, 8'd20,  8'd10,  1'b1, '{8'd0,  8'd23, 8'd0, 8'd23, 1'b0, 1'b0, 1'b1}},
    '{OP_REGION, 8'd5,   8'd5,   1'b1, '{8'd0,  8'd23, 8'd0, 8'd23, 1'b0, 1'b0, 1'b1}},
    '{OP_REGION, 8'd255, 8'd255, 1'b1, '{8'd0,  8'd23, 8'd0, 8'd23, 1'b0, 1'b0, 1'b1}},
    '{OP_REGION, 8'd5,   8'd10,  1'b1, '{8'd0,  8'd0,  8'd5, 8'd10, 1'b0, 1'b0, 1'b0}},
    '{OP_UP,     8'd3,   8'd0,   1'b0, '0},
    '{OP_DOWN,   8'd255, 8'd0,   1'b0, '0},
    '{OP_RI,     8'd0,   8'd0,   1'b0, '0},
    '{OP_UP,     8'd0,   8'd0,   1'b0, '0},
    '{OP_UP,     8'd255, 8'd0,   1'b0, '0},
    '{OP_RI,     8'd0,   8'd0,   1'b0, '0},
    '{OP_MOVE,   8'd0,   8'd20,  1'b0, '0},
    '{OP_DOWN,   8'd255, 8'd0,   1'b0, '0},
    '{OP_LF,     8'd0,   8'd0,   1'b0, '0},
    '{OP_UP,     8'd255, 8'd0,   1'b0, '0},
    '{OP_MOVE,   8'd40,  8'd0,   1'b0, '0},
    '{OP_LEFT,   8'd255, 8'd0,   1'b0, '0},
    '{4'd9,      8'd170, 8'd85,  1'b0, '0},
    '{4'd15,     8'd85,  8'd170, 1'b0, '0},
    '{OP_REGION, 8'd0,   8'd23,  1'b1, '{8'd0,  8'd0,  8'd0, 8'd23, 1'b0, 1'b0, 1'b0}},
    '{OP_RIGHT,  8'd1,   8'd0,   1'b0, '0}
  };

  function automatic int last_cell(input logic [CFG_W-1:0] size);
    if (size == '0) return 0;
    if (int'(size) > (1 << COORD_BITS)) return (1 << COORD_BITS) - 1;
    return int'(size) - 1;
  endfunction

  function automatic int lesser(input int x, input int y);
    return (x < y) ? x : y;
  endfunction

  // Distance toward an edge; a cursor past the edge does not move
  function automatic int headroom(input int edge_pos, input int pos);
    return (edge_pos > pos) ? edge_pos - pos : 0;
  endfunction

  // Apply one command to the predicted terminal and return the view after it
  task automatic advance_terminal(input command_t c, output cursor_view_t v);
    int cx, cy, top, bot, lc, lr, n, t, u;
    cx  = term_col;
    cy  = term_row;
    top = scroll_top;
    bot = scroll_bot;
    lc  = last_cell(cfg_cols);
    lr  = last_cell(cfg_rows);
    n   = (c.first == '0) ? 1 : int'(c.first);
    v   = '0;
    case (c.op)
      OP_UP: begin
        n  = lesser(n, (cy < top) ? cy : cy - top);
        cy = cy - n;
      end
      OP_DOWN: begin
        n  = lesser(n, (cy > bot) ? headroom(lr, cy) : bot - cy);
        cy = cy + n;
      end
      OP_RIGHT: cx = cx + lesser(n, headroom(lc, cx));
      OP_LEFT:  cx = cx - lesser(n, cx);
      OP_MOVE: begin
        cx = lesser(c.first, lc);
        cy = lesser(c.second, lr);
      end
      OP_REGION: begin
        t = lesser(c.first, lr);
        u = lesser(c.second, lr);
        if (t >= u) begin
          v.rejected = 1'b1;
        end else begin
          cx  = 0;
          cy  = 0;
          top = t;
          bot = u;
        end
      end
      OP_LF: begin
        if (cy == bot) v.scroll_up = 1'b1;
        else if (cy < lr) cy = cy + 1;
      end
      OP_RI: begin
        if (cy == top) v.scroll_down = 1'b1;
        else if (cy > 0) cy = cy - 1;
      end
      OP_CR: cx = 0;
      default: ;
    endcase
    term_col   = OUT_W'(cx);
    term_row   = OUT_W'(cy);
    scroll_top = OUT_W'(top);
    scroll_bot = OUT_W'(bot);
    v.col = term_col;
    v.row = term_row;
    v.top = scroll_top;
    v.bot = scroll_bot;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < MAX_PRINTED)
      $display("%0t: mismatch in %s on result %0d: got %0d, want %0d",
               $realtime, what, views_checked, got, want);
    mismatches++;
  endtask

  // Compare one delivered result with the oldest pending view
  task automatic check_view(input cursor_view_t got);
    cursor_view_t want;
    if (expected_views.size() == 0) begin
      report_mismatch("result with nothing pending", got.col, 0);
      return;
    end
    want = expected_views.pop_front();
    if (got.col != want.col)                 report_mismatch("cursor_col", got.col, want.col);
    if (got.row != want.row)                 report_mismatch("cursor_row", got.row, want.row);
    if (got.top != want.top)                 report_mismatch("region_top", got.top, want.top);
    if (got.bot != want.bot)                 report_mismatch("region_bottom", got.bot, want.bot);
    if (got.scroll_up != want.scroll_up)     report_mismatch("scroll_up", got.scroll_up,
                                                             want.scroll_up);
    if (got.scroll_down != want.scroll_down) report_mismatch("scroll_down", got.scroll_down,
                                                             want.scroll_down);
    if (got.rejected != want.rejected)       report_mismatch("region_rejected", got.rejected,
                                                             want.rejected);
  endtask

  // Argument biased toward small counts and the screen edge
  function automatic logic [ARG_W-1:0] pick_arg(input int lim);
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 3);
      1: v = $urandom_range(0, 255);
      2: v = lim + $urandom_range(0, 4) - 2;
      default: v = $urandom_range(0, lim);
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return ARG_W'(v);
  endfunction

  function automatic command_t random_command();
    command_t c;
    int lc, lr;
    lc = last_cell(cfg_cols);
    lr = last_cell(cfg_rows);
    if ($urandom_range(0, 99) < 95) c.op = OP_W'($urandom_range(0, 8));
    else c.op = OP_W'($urandom_range(9, 15));
    c.first  = ARG_W'($urandom_range(0, 255));
    c.second = ARG_W'($urandom_range(0, 255));
    case (c.op)
      OP_MOVE: begin
        c.first  = pick_arg(lc);
        c.second = pick_arg(lr);
      end
      OP_REGION: begin
        // Mostly valid regions so that later moves run inside them
        if ($urandom_range(0, 9) < 6) begin
          c.first  = ARG_W'($urandom_range(0, lr));
          c.second = ARG_W'($urandom_range(c.first, lr));
        end else begin
          c.first  = pick_arg(lr);
          c.second = pick_arg(lr);
        end
      end
      OP_UP, OP_DOWN: c.first = pick_arg(lr);
      OP_RIGHT, OP_LEFT: c.first = pick_arg(lc);
      default: ;
    endcase
    return c;
  endfunction

  // Offer one command and record its expected view once the transfer happens
  task automatic issue_command(input command_t c, input logic typed,
                               input cursor_view_t typed_view);
    int unsigned gap;
    cursor_view_t predicted;
    if ($urandom_range(0, 23) == 0) sender_lazy = !sender_lazy;
    gap = sender_lazy ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, c.second, c.first, c.op};
    do @(posedge clk_i); while (!s_axis_tready);
    advance_terminal(c, predicted);
    expected_views.push_back(typed ? typed_view : predicted);
  endtask

  // Hold input until every result is back, then let the pipeline settle
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_screen_size(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] size);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= size;
    @(posedge clk_i);
    if (idx == REG_COLS) begin
      cfg_cols = size;
      if (term_col > last_cell(cfg_cols)) term_col = OUT_W'(last_cell(cfg_cols));
    end else begin
      cfg_rows   = size;
      scroll_top = '0;
      scroll_bot = OUT_W'(last_cell(cfg_rows));
      if (term_row > last_cell(cfg_rows)) term_row = OUT_W'(last_cell(cfg_rows));
    end
  endtask

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Main stimulus: opening table, then random phases on several screen sizes
  initial begin : stimulus
    int p;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_COLS;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    mismatches    = 0;
    sender_lazy   = 1'b1;
    cfg_cols      = COLS_RESET;
    cfg_rows      = ROWS_RESET;
    term_col      = '0;
    term_row      = '0;
    scroll_top    = '0;
    scroll_bot    = OUT_W'(last_cell(ROWS_RESET));
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening_rows[k])
      issue_command(command_t'({opening_rows[k].op, opening_rows[k].first,
                                opening_rows[k].second}),
                    opening_rows[k].typed, opening_rows[k].view);

    for (p = 0; p < PHASES; p++) begin
      drain_results();
      write_screen_size(REG_COLS, phase_cols[p]);
      write_screen_size(REG_ROWS, phase_rows[p]);
      cfg_we_i <= 1'b0;
      repeat (ITEMS_PER_PHASE) issue_command(random_command(), 1'b0, '0);
    end

    drain_results();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result side: random back-pressure and one long hold to fill the block
  initial begin : result_sink
    int unsigned gap;
    bit long_hold_done;
    m_axis_tready  = 1'b0;
    views_checked  = 0;
    receiver_lazy  = 1'b0;
    long_hold_done = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 23) == 0) receiver_lazy = !receiver_lazy;
      gap = receiver_lazy ? $urandom_range(0, 16) : 0;
      if (!long_hold_done && views_checked == LONG_HOLD_AT) begin
        gap = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      check_view({m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                  m_axis_tdata[31:24], m_axis_tuser[0], m_axis_tuser[1], m_axis_tuser[2]});
      views_checked++;
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule

/* files.f */
hdl/trcc_pkg.sv
hdl/trcc_step.sv
hdl/trcc_state.sv
hdl/terminal_cursor_region_control.sv
dv/terminal_cursor_region_control_tb.sv
